// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: rtl/whp_pkg.sv
// ----------------------------------------------------------------------------
// whp_pkg
// types, codes and constants shared by the wav header parser modules
// ----------------------------------------------------------------------------
package whp_pkg;

  typedef enum logic [4:0] {
    PH_RIFF, PH_RIFFSIZE, PH_WAVE, PH_ID1, PH_JUNKSIZE, PH_JUNKSKIP,
    PH_FMTID, PH_FMTSIZE, PH_AUDIOFMT, PH_CHANNELS, PH_RATE, PH_BYTERATE,
    PH_ALIGN, PH_BITS, PH_EXT, PH_CHUNKID, PH_CHUNKSIZE, PH_CHUNKSKIP,
    PH_DATASIZE, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    M_RUN, M_DIV, M_REPORT
  } mode_t;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_RIFF        = 4'd1,
    ST_WAVE        = 4'd2,
    ST_FMT_ID      = 4'd3,
    ST_FMT_SIZE    = 4'd4,
    ST_AUDIO_FMT   = 4'd5,
    ST_CHANNELS    = 4'd6,
    ST_RATE        = 4'd7,
    ST_BITS        = 4'd8,
    ST_TRUNCATED   = 4'd9,
    ST_ZERO_ALIGN  = 4'd10
  } status_t;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_JUNK = 32'h4B4E_554A;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_SIZE_PLAIN = 32'd16;
  localparam logic [31:0] FMT_SIZE_EXT   = 32'd18;
  localparam logic [31:0] PCM_FORMAT     = 32'd1;
  localparam logic [31:0] PCM_BITS       = 32'd16;
  localparam logic [31:0] RATE_32K       = 32'd32000;
  localparam logic [31:0] RATE_44K1      = 32'd44100;
  localparam logic [31:0] RATE_48K       = 32'd48000;

  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic first;
    logic active;
    logic skip_phase;
    logic short_field;
    logic load_skip;
    logic load_ext;
    logic load_chan;
    logic load_rate;
    logic load_brate;
    logic load_align;
    logic load_bits;
    logic start_div;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic field_done;
    logic skip_last;
    logic v_riff;
    logic v_wave;
    logic v_junk;
    logic v_fmt;
    logic v_data;
    logic v_one;
    logic v_two;
    logic v_sixteen;
    logic v_eighteen;
    logic v_rate_ok;
    logic v_zero;
    logic ext_fmt;
    logic align_zero;
    logic div_done;
  } dp_flags_t;

endpackage

// File: rtl/wav_header_parser.sv
// wav header parser: one file byte is taken per cycle while parsing
// out_valid rises when the report state loads the result register, once the output slot is free;
// an ok result first goes through the 32-step serial frame count divide
// no byte is taken from that deciding byte until the result is loaded
// reset (rst, synchronous): parser waits for the riff tag, output register empty
// ----------------------------------------------------------------------------
// wav_header_parser
// byte-serial riff/wave pcm header checker with a single registered result
// ----------------------------------------------------------------------------
module wav_header_parser
  import whp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  status,
  output logic [15:0] channel_count,
  output logic [31:0] rate_hz,
  output logic [31:0] bytes_per_sec,
  output logic [15:0] frame_bytes,
  output logic [15:0] sample_bits,
  output logic [31:0] frame_count,
  output logic [31:0] header_length
);

  dp_cmd_t     cmd;
  dp_flags_t   flags;
  status_t     result_status;
  logic        out_load, out_free;
  logic [15:0] held_channels, held_align, held_bits;
  logic [31:0] held_rate, held_byte_rate, byte_position, quotient;

  // the output slot is free when empty or being drained this cycle
  assign out_free = !out_valid || out_ready;

  whp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .first_byte   (first_byte),
    .last_byte    (last_byte),
    .flags        (flags),
    .out_free     (out_free),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .out_load     (out_load),
    .result_status(result_status)
  );

  whp_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .data_byte     (data_byte),
    .cmd           (cmd),
    .flags         (flags),
    .held_channels (held_channels),
    .held_rate     (held_rate),
    .held_byte_rate(held_byte_rate),
    .held_align    (held_align),
    .held_bits     (held_bits),
    .byte_position (byte_position),
    .quotient      (quotient)
  );

  // result transfer register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload: frame count and header length only reported on success
  always_ff @(posedge clk) begin
    if (out_load) begin
      status        <= result_status;
      channel_count <= held_channels;
      rate_hz       <= held_rate;
      bytes_per_sec <= held_byte_rate;
      frame_bytes   <= held_align;
      sample_bits   <= held_bits;
      frame_count   <= (result_status == ST_OK) ? quotient : '0;
      header_length <= (result_status == ST_OK) ? byte_position : '0;
    end
  end

endmodule

// File: rtl/whp_datapath.sv
// ----------------------------------------------------------------------------
// whp_datapath
// field assembly, skip and position counters, held format fields and a
// one bit per cycle restoring divider for the frame count
// ----------------------------------------------------------------------------
module whp_datapath
  import whp_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      data_byte,
  input  dp_cmd_t         cmd,
  output dp_flags_t       flags,
  output logic [15:0]     held_channels,
  output logic [31:0]     held_rate,
  output logic [31:0]     held_byte_rate,
  output logic [15:0]     held_align,
  output logic [15:0]     held_bits,
  output logic [31:0]     byte_position,
  output logic [31:0]     quotient
);

  logic [1:0]  field_byte_index, eff_idx, idx_next;
  logic [31:0] field_shift, eff_shift, shift_next, v;
  logic [31:0] skip_remaining, eff_skip, skip_next;
  logic [31:0] eff_pos, pos_next;
  logic        extended_fmt, eff_ext, ext_next;
  logic [15:0] eff_chan, chan_next, eff_align, align_next, eff_bits, bits_next;
  logic [31:0] eff_rate, rate_next, eff_brate, brate_next;
  logic [15:0] remainder;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [16:0] trial;
  logic        trial_ge;

  // a first byte sees the state as after reset
  always_comb begin
    eff_idx   = cmd.first ? 2'd0  : field_byte_index;
    eff_shift = cmd.first ? '0    : field_shift;
    eff_skip  = cmd.first ? '0    : skip_remaining;
    eff_pos   = cmd.first ? '0    : byte_position;
    eff_ext   = cmd.first ? 1'b0  : extended_fmt;
    eff_chan  = cmd.first ? '0    : held_channels;
    eff_rate  = cmd.first ? '0    : held_rate;
    eff_brate = cmd.first ? '0    : held_byte_rate;
    eff_align = cmd.first ? '0    : held_align;
    eff_bits  = cmd.first ? '0    : held_bits;
  end

  assign v = eff_shift | (32'(data_byte) << {eff_idx, 3'b000});

  always_comb begin
    flags            = '0;
    flags.field_done = cmd.short_field ? (eff_idx == 2'd1) : (eff_idx == 2'd3);
    flags.skip_last  = (eff_skip == 32'd1);
    flags.v_riff     = (v == TAG_RIFF);
    flags.v_wave     = (v == TAG_WAVE);
    flags.v_junk     = (v == TAG_JUNK);
    flags.v_fmt      = (v == TAG_FMT);
    flags.v_data     = (v == TAG_DATA);
    flags.v_one      = (v == PCM_FORMAT);
    flags.v_two      = (v == 32'd2);
    flags.v_sixteen  = (v == FMT_SIZE_PLAIN);
    flags.v_eighteen = (v == FMT_SIZE_EXT);
    flags.v_rate_ok  = (v == RATE_32K) || (v == RATE_44K1) || (v == RATE_48K);
    flags.v_zero     = (v == 32'd0);
    flags.ext_fmt    = eff_ext;
    flags.align_zero = (eff_align == 16'd0);
    flags.div_done   = (div_cnt == DIV_CNT_W'(1));
  end

  always_comb begin
    idx_next   = eff_idx;
    shift_next = eff_shift;
    skip_next  = eff_skip;
    pos_next   = eff_pos;
    ext_next   = eff_ext;
    chan_next  = eff_chan;
    rate_next  = eff_rate;
    brate_next = eff_brate;
    align_next = eff_align;
    bits_next  = eff_bits;
    if (cmd.active) begin
      pos_next = eff_pos + 32'd1;
      if (cmd.skip_phase) begin
        skip_next = eff_skip - 32'd1;
      end else if (flags.field_done) begin
        idx_next   = 2'd0;
        shift_next = '0;
      end else begin
        idx_next   = eff_idx + 2'd1;
        shift_next = v;
      end
      if (cmd.load_skip)  skip_next  = v;
      if (cmd.load_ext)   ext_next   = flags.v_eighteen;
      if (cmd.load_chan)  chan_next  = v[15:0];
      if (cmd.load_rate)  rate_next  = v;
      if (cmd.load_brate) brate_next = v;
      if (cmd.load_align) align_next = v[15:0];
      if (cmd.load_bits)  bits_next  = v[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_byte_index <= '0;
      field_shift      <= '0;
      skip_remaining   <= '0;
      byte_position    <= '0;
      extended_fmt     <= 1'b0;
      held_channels    <= '0;
      held_rate        <= '0;
      held_byte_rate   <= '0;
      held_align       <= '0;
      held_bits        <= '0;
    end else if (cmd.accept) begin
      field_byte_index <= idx_next;
      field_shift      <= shift_next;
      skip_remaining   <= skip_next;
      byte_position    <= pos_next;
      extended_fmt     <= ext_next;
      held_channels    <= chan_next;
      held_rate        <= rate_next;
      held_byte_rate   <= brate_next;
      held_align       <= align_next;
      held_bits        <= bits_next;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign trial    = {remainder, quotient[31]};
  assign trial_ge = (trial >= {1'b0, held_align});

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.start_div) begin
      div_cnt <= DIV_CNT_W'(DIV_STEPS);
    end else if (div_cnt != '0) begin
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      quotient  <= v;
      remainder <= '0;
    end else if (div_cnt != '0) begin
      quotient  <= {quotient[30:0], trial_ge};
      remainder <= trial_ge ? 16'(trial - {1'b0, held_align}) : trial[15:0];
    end
  end

endmodule

// File: rtl/whp_ctrl.sv
// ----------------------------------------------------------------------------
// whp_ctrl
// parse phase sequencer and result control for the wav header parser
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module whp_ctrl
  import whp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      first_byte,
  input  logic      last_byte,
  input  dp_flags_t flags,
  input  logic      out_free,
  output logic      in_ready,
  output dp_cmd_t   cmd,
  output logic      out_load,
  output status_t   result_status
);

  phase_t  phase, phase_next, eff_phase;
  mode_t   mode, mode_next;
  status_t status_next, code;
  logic    accept, found;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_RIFF;
      mode          <= M_RUN;
      result_status <= ST_OK;
    end else begin
      phase         <= phase_next;
      mode          <= mode_next;
      result_status <= status_next;
    end
  end

  assign in_ready  = (mode == M_RUN);
  assign accept    = in_valid && in_ready;
  assign eff_phase = first_byte ? PH_RIFF : phase;

  always_comb begin
    cmd         = '0;
    cmd.accept  = accept;
    cmd.first   = first_byte;
    phase_next  = phase;
    mode_next   = mode;
    status_next = result_status;
    out_load    = 1'b0;
    found       = 1'b0;
    code        = ST_OK;
    unique case (mode)
      M_RUN: begin
        if (accept) begin
          phase_next = eff_phase;
          if (eff_phase != PH_DONE) begin
            cmd.active      = 1'b1;
            cmd.skip_phase  = (eff_phase == PH_JUNKSKIP) || (eff_phase == PH_CHUNKSKIP);
            cmd.short_field = (eff_phase == PH_AUDIOFMT) || (eff_phase == PH_CHANNELS) ||
                              (eff_phase == PH_ALIGN) || (eff_phase == PH_BITS) ||
                              (eff_phase == PH_EXT);
            if (cmd.skip_phase) begin
              if (flags.skip_last) begin
                phase_next = (eff_phase == PH_JUNKSKIP) ? PH_FMTID : PH_CHUNKID;
              end
            end else if (flags.field_done) begin
              unique case (eff_phase)
                PH_RIFF: begin
                  if (!flags.v_riff) begin found = 1'b1; code = ST_RIFF; end
                  else phase_next = PH_RIFFSIZE;
                end
                PH_RIFFSIZE: phase_next = PH_WAVE;
                PH_WAVE: begin
                  if (!flags.v_wave) begin found = 1'b1; code = ST_WAVE; end
                  else phase_next = PH_ID1;
                end
                PH_ID1: begin
                  if (flags.v_junk) phase_next = PH_JUNKSIZE;
                  else if (flags.v_fmt) phase_next = PH_FMTSIZE;
                  else begin found = 1'b1; code = ST_FMT_ID; end
                end
                PH_JUNKSIZE: begin
                  cmd.load_skip = 1'b1;
                  phase_next    = flags.v_zero ? PH_FMTID : PH_JUNKSKIP;
                end
                PH_FMTID: begin
                  if (!flags.v_fmt) begin found = 1'b1; code = ST_FMT_ID; end
                  else phase_next = PH_FMTSIZE;
                end
                PH_FMTSIZE: begin
                  if (!flags.v_sixteen && !flags.v_eighteen) begin
                    found = 1'b1;
                    code  = ST_FMT_SIZE;
                  end else begin
                    cmd.load_ext = 1'b1;
                    phase_next   = PH_AUDIOFMT;
                  end
                end
                PH_AUDIOFMT: begin
                  if (!flags.v_one) begin found = 1'b1; code = ST_AUDIO_FMT; end
                  else phase_next = PH_CHANNELS;
                end
                PH_CHANNELS: begin
                  cmd.load_chan = 1'b1;
                  if (!flags.v_one && !flags.v_two) begin
                    found = 1'b1;
                    code  = ST_CHANNELS;
                  end else phase_next = PH_RATE;
                end
                PH_RATE: begin
                  cmd.load_rate = 1'b1;
                  if (!flags.v_rate_ok) begin found = 1'b1; code = ST_RATE; end
                  else phase_next = PH_BYTERATE;
                end
                PH_BYTERATE: begin
                  cmd.load_brate = 1'b1;
                  phase_next     = PH_ALIGN;
                end
                PH_ALIGN: begin
                  cmd.load_align = 1'b1;
                  phase_next     = PH_BITS;
                end
                PH_BITS: begin
                  cmd.load_bits = 1'b1;
                  if (!flags.v_sixteen) begin found = 1'b1; code = ST_BITS; end
                  else phase_next = flags.ext_fmt ? PH_EXT : PH_CHUNKID;
                end
                PH_EXT: phase_next = PH_CHUNKID;
                PH_CHUNKID: phase_next = flags.v_data ? PH_DATASIZE : PH_CHUNKSIZE;
                PH_CHUNKSIZE: begin
                  cmd.load_skip = 1'b1;
                  phase_next    = flags.v_zero ? PH_CHUNKID : PH_CHUNKSKIP;
                end
                PH_DATASIZE: begin
                  found = 1'b1;
                  code  = flags.align_zero ? ST_ZERO_ALIGN : ST_OK;
                end
                default: ;
              endcase
            end
            if (!found && last_byte) begin
              found = 1'b1;
              code  = ST_TRUNCATED;
            end
            if (found) begin
              phase_next    = PH_DONE;
              status_next   = code;
              cmd.start_div = (code == ST_OK);
              mode_next     = (code == ST_OK) ? M_DIV : M_REPORT;
            end
          end
        end
      end
      M_DIV: begin
        if (flags.div_done) mode_next = M_REPORT;
      end
      M_REPORT: begin
        if (out_free) begin
          out_load  = 1'b1;
          mode_next = M_RUN;
        end
      end
      default: mode_next = M_RUN;
    endcase
  end

  `ASSERT_NEXT(a_result_leaves_run, cmd.active && found, mode != M_RUN, "result byte did not stop intake")
  `ASSERT_IMPL(a_div_only_when_done, mode == M_DIV, phase == PH_DONE, "division outside done phase")
  `ASSERT_NEXT(a_report_returns, out_load, mode == M_RUN && phase == PH_DONE, "report did not return to run")
  `ASSERT_IMPL(a_div_ok_status, mode == M_DIV, result_status == ST_OK, "division for an error result")

endmodule

// File: tb/wav_header_parser_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wav_header_parser_test
// streams whole wav files byte by byte into the header parser, predicts the
// single report of each file and checks every report field by field
// ----------------------------------------------------------------------------
module wav_header_parser_test;
  import whp_pkg::*;

  localparam int QUIET_LIMIT  = 4000; // cycles with no transfer before giving up
  localparam int DRAIN_CYCLES = 64;   // room for a serial divide and its report to drain
  localparam int HOLD_CYCLES  = 300;  // long output hold-off for the pressure test

  // one report as the parser should present it
  typedef struct packed {
    status_t     status;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [31:0] brate;
    logic [15:0] align;
    logic [15:0] bits;
    logic [31:0] frames;
    logic [31:0] hlen;
  } header_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        first_byte = 1'b0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  status;
  logic [15:0] channel_count;
  logic [31:0] rate_hz;
  logic [31:0] bytes_per_sec;
  logic [15:0] frame_bytes;
  logic [15:0] sample_bits;
  logic [31:0] frame_count;
  logic [31:0] header_length;

  wav_header_parser uut (.*);

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // header tracker: our own copy of the parser state, advanced once per
  // accepted byte, queuing the report that the byte causes
  // ---------------------------------------------------------------------------
  phase_t      hdr_phase;
  logic [1:0]  hdr_idx;
  logic [31:0] hdr_shift;
  logic [31:0] hdr_skip;
  logic [31:0] hdr_pos;
  logic        hdr_ext;
  logic [15:0] hdr_channels;
  logic [31:0] hdr_rate;
  logic [31:0] hdr_brate;
  logic [15:0] hdr_align;
  logic [15:0] hdr_bits;
  logic        hdr_finished;

  header_report_t expected_reports[$];
  int reports_predicted = 0;
  int bytes_sent = 0;
  int mismatches = 0;

  task automatic clear_tracker();
    hdr_phase    = PH_RIFF;
    hdr_idx      = 2'd0;
    hdr_shift    = '0;
    hdr_skip     = '0;
    hdr_pos      = '0;
    hdr_ext      = 1'b0;
    hdr_channels = '0;
    hdr_rate     = '0;
    hdr_brate    = '0;
    hdr_align    = '0;
    hdr_bits     = '0;
    hdr_finished = 1'b0;
  endtask

  task automatic track_header(input logic [7:0] b, input logic first, input logic last);
    logic [31:0]    word;
    logic [1:0]     width_mod;
    logic           report;
    status_t        code;
    logic [31:0]    frames;
    logic [31:0]    hlen;
    header_report_t rep;
    report = 1'b0;
    code   = ST_OK;
    frames = '0;
    hlen   = '0;
    word   = '0;
    // first_byte restarts the parser even after a report
    if (first)
      clear_tracker();
    if (!hdr_finished && hdr_phase != PH_DONE) begin
      hdr_pos = hdr_pos + 32'd1;
      if (hdr_phase == PH_JUNKSKIP || hdr_phase == PH_CHUNKSKIP) begin
        // skipping chunk body, exactly size bytes, no pad byte
        hdr_skip = hdr_skip - 32'd1;
        if (hdr_skip == 32'd0)
          hdr_phase = (hdr_phase == PH_JUNKSKIP) ? PH_FMTID : PH_CHUNKID;
      end else begin
        // little-endian field assembly
        hdr_shift = hdr_shift | ({24'd0, b} << {hdr_idx, 3'b000});
        hdr_idx   = hdr_idx + 2'd1;
        case (hdr_phase)
          PH_AUDIOFMT, PH_CHANNELS, PH_ALIGN, PH_BITS, PH_EXT: width_mod = 2'd2;
          default: width_mod = 2'd0;
        endcase
        if (hdr_idx == width_mod) begin
          word      = hdr_shift;
          hdr_shift = '0;
          hdr_idx   = 2'd0;
          case (hdr_phase)
            PH_RIFF: begin
              if (word != TAG_RIFF) begin
                report = 1'b1;
                code   = ST_RIFF;
              end else hdr_phase = PH_RIFFSIZE;
            end
            PH_RIFFSIZE: hdr_phase = PH_WAVE;
            PH_WAVE: begin
              if (word != TAG_WAVE) begin
                report = 1'b1;
                code   = ST_WAVE;
              end else hdr_phase = PH_ID1;
            end
            PH_ID1: begin
              if (word == TAG_JUNK) hdr_phase = PH_JUNKSIZE;
              else if (word == TAG_FMT) hdr_phase = PH_FMTSIZE;
              else begin
                report = 1'b1;
                code   = ST_FMT_ID;
              end
            end
            PH_JUNKSIZE: begin
              // a zero size junk chunk goes straight to the fmt id
              hdr_skip  = word;
              hdr_phase = (word == 32'd0) ? PH_FMTID : PH_JUNKSKIP;
            end
            PH_FMTID: begin
              if (word != TAG_FMT) begin
                report = 1'b1;
                code   = ST_FMT_ID;
              end else hdr_phase = PH_FMTSIZE;
            end
            PH_FMTSIZE: begin
              if (word != FMT_SIZE_PLAIN && word != FMT_SIZE_EXT) begin
                report = 1'b1;
                code   = ST_FMT_SIZE;
              end else begin
                hdr_ext   = (word == FMT_SIZE_EXT);
                hdr_phase = PH_AUDIOFMT;
              end
            end
            PH_AUDIOFMT: begin
              if (word != PCM_FORMAT) begin
                report = 1'b1;
                code   = ST_AUDIO_FMT;
              end else hdr_phase = PH_CHANNELS;
            end
            PH_CHANNELS: begin
              hdr_channels = word[15:0];
              if (word != 32'd1 && word != 32'd2) begin
                report = 1'b1;
                code   = ST_CHANNELS;
              end else hdr_phase = PH_RATE;
            end
            PH_RATE: begin
              hdr_rate = word;
              if (word != RATE_32K && word != RATE_44K1 && word != RATE_48K) begin
                report = 1'b1;
                code   = ST_RATE;
              end else hdr_phase = PH_BYTERATE;
            end
            PH_BYTERATE: begin
              hdr_brate = word;
              hdr_phase = PH_ALIGN;
            end
            PH_ALIGN: begin
              hdr_align = word[15:0];
              hdr_phase = PH_BITS;
            end
            PH_BITS: begin
              hdr_bits = word[15:0];
              if (word != PCM_BITS) begin
                report = 1'b1;
                code   = ST_BITS;
              end else hdr_phase = hdr_ext ? PH_EXT : PH_CHUNKID;
            end
            PH_EXT: hdr_phase = PH_CHUNKID;
            PH_CHUNKID: hdr_phase = (word == TAG_DATA) ? PH_DATASIZE : PH_CHUNKSIZE;
            PH_CHUNKSIZE: begin
              hdr_skip  = word;
              hdr_phase = (word == 32'd0) ? PH_CHUNKID : PH_CHUNKSKIP;
            end
            PH_DATASIZE: begin
              report = 1'b1;
              if (hdr_align == 16'd0) code = ST_ZERO_ALIGN;
              else begin
                code   = ST_OK;
                frames = word / {16'd0, hdr_align};
                hlen   = hdr_pos;
              end
            end
            default: ;
          endcase
        end
      end
      // an error on the last byte keeps its own code
      if (!report && last) begin
        report = 1'b1;
        code   = ST_TRUNCATED;
      end
      if (report) begin
        hdr_finished = 1'b1;
        hdr_phase    = PH_DONE;
        rep.status   = code;
        rep.channels = hdr_channels;
        rep.rate     = hdr_rate;
        rep.brate    = hdr_brate;
        rep.align    = hdr_align;
        rep.bits     = hdr_bits;
        rep.frames   = frames;
        rep.hlen     = hlen;
        expected_reports.push_back(rep);
        reports_predicted++;
      end
    end
  endtask

  initial clear_tracker();

  // ---------------------------------------------------------------------------
  // report checker: every output transfer against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_report();
    header_report_t want;
    if (expected_reports.size() == 0) begin
      $display("%0t: unexpected report, expected none, actual status %0d", $time, status);
      mismatches++;
    end else begin
      want = expected_reports.pop_front();
      check_field("status", 32'(want.status), 32'(status));
      check_field("channel_count", 32'(want.channels), 32'(channel_count));
      check_field("rate_hz", want.rate, rate_hz);
      check_field("bytes_per_sec", want.brate, bytes_per_sec);
      check_field("frame_bytes", 32'(want.align), 32'(frame_bytes));
      check_field("sample_bits", 32'(want.bits), 32'(sample_bits));
      check_field("frame_count", want.frames, frame_count);
      check_field("header_length", want.hlen, header_length);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      check_report();
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  int stall_pct = 0;
  int send_idle_pct = 0;
  int hold_left = 0;
  bit hold_request = 1'b0;

  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: too long without any transfer means the block is stuck
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else quiet_cycles <= quiet_cycles + 1;
  end

  // ---------------------------------------------------------------------------
  // byte sender: one transfer per call, random idle cycles in front
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [7:0] b, input logic first, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    first_byte <= first;
    last_byte  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_header(b, first, last);
    bytes_sent++;
  endtask

  task automatic set_idling(input int idle, input int stall);
    send_idle_pct = idle;
    stall_pct     = stall;
  endtask

  // ---------------------------------------------------------------------------
  // file builder: a header recipe turned into a byte queue
  // ---------------------------------------------------------------------------
  logic [7:0]  wav_bytes[$];
  logic [31:0] rc_riff, rc_riff_size, rc_wave, rc_junk_size, rc_fmt_id, rc_fmt_size;
  logic [31:0] rc_rate, rc_brate, rc_data_size;
  logic [15:0] rc_audio, rc_chans, rc_align, rc_bits, rc_ext;
  logic [31:0] rc_chunk_size[0:1];
  bit          rc_junk, rc_cut, rc_flip;
  int          rc_chunks, rc_tail;

  task automatic put_le(input logic [31:0] value, input int nbytes);
    for (int i = 0; i < nbytes; i++)
      wav_bytes.push_back(value[8*i +: 8]);
  endtask

  task automatic put_random(input int count);
    repeat (count) put_le($urandom, 1);
  endtask

  // body bytes of long chunks are capped at 64, so the following bytes fall inside the declared body
  task automatic put_body(input logic [31:0] size);
    put_random((size > 32'd64) ? 64 : size);
  endtask

  task automatic clean_recipe();
    rc_riff      = TAG_RIFF;
    rc_riff_size = 32'd36;
    rc_wave      = TAG_WAVE;
    rc_junk      = 1'b0;
    rc_junk_size = 32'd0;
    rc_fmt_id    = TAG_FMT;
    rc_fmt_size  = FMT_SIZE_PLAIN;
    rc_audio     = 16'(PCM_FORMAT);
    rc_chans     = 16'd2;
    rc_rate      = RATE_44K1;
    rc_brate     = 32'd176400;
    rc_align     = 16'd4;
    rc_bits      = 16'(PCM_BITS);
    rc_ext       = 16'd0;
    rc_chunks    = 0;
    rc_chunk_size[0] = 32'd0;
    rc_chunk_size[1] = 32'd0;
    rc_data_size = 32'd1024;
    rc_tail      = 0;
    rc_cut       = 1'b0;
    rc_flip      = 1'b0;
  endtask

  task automatic build_file();
    wav_bytes.delete();
    put_le(rc_riff, 4);
    put_le(rc_riff_size, 4);
    put_le(rc_wave, 4);
    if (rc_junk) begin
      put_le(TAG_JUNK, 4);
      put_le(rc_junk_size, 4);
      put_body(rc_junk_size);
    end
    put_le(rc_fmt_id, 4);
    put_le(rc_fmt_size, 4);
    put_le(32'(rc_audio), 2);
    put_le(32'(rc_chans), 2);
    put_le(rc_rate, 4);
    put_le(rc_brate, 4);
    put_le(32'(rc_align), 2);
    put_le(32'(rc_bits), 2);
    if (rc_fmt_size == FMT_SIZE_EXT)
      put_le(32'(rc_ext), 2);
    for (int i = 0; i < rc_chunks; i++) begin
      put_le($urandom, 4);
      put_le(rc_chunk_size[i], 4);
      put_body(rc_chunk_size[i]);
    end
    put_le(TAG_DATA, 4);
    put_le(rc_data_size, 4);
    put_random(rc_tail);
  endtask

  task automatic cut_file(input int keep);
    while (wav_bytes.size() > keep) void'(wav_bytes.pop_back());
  endtask

  task automatic send_file(input bit with_first, input bit with_last);
    int n;
    n = wav_bytes.size();
    for (int i = 0; i < n; i++)
      send_item(wav_bytes[i], with_first && (i == 0), with_last && (i == n - 1));
  endtask

  // ---------------------------------------------------------------------------
  // random recipes: mostly well-formed with random content, some faulted
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] pick_chunk_size();
    int r;
    r = $urandom_range(19);
    if (r == 0) return 32'd0;
    else if (r == 1) return $urandom;
    else return $urandom_range(1, 12);
  endfunction

  task automatic random_recipe();
    int r;
    clean_recipe();
    rc_riff_size = $urandom;
    rc_junk      = ($urandom_range(2) == 0);
    rc_junk_size = pick_chunk_size();
    rc_fmt_size  = $urandom_range(1) ? FMT_SIZE_PLAIN : FMT_SIZE_EXT;
    rc_chans     = 16'($urandom_range(1, 2));
    r = $urandom_range(2);
    rc_rate      = (r == 0) ? RATE_32K : (r == 1) ? RATE_44K1 : RATE_48K;
    rc_brate     = $urandom;
    r = $urandom_range(9);
    rc_align     = (r == 0) ? 16'd1 : (r == 1) ? 16'hFFFF : (r == 2) ? 16'($urandom) :
                   16'($urandom_range(1, 8));
    rc_ext       = 16'($urandom);
    rc_chunks    = $urandom_range(2);
    rc_chunk_size[0] = pick_chunk_size();
    rc_chunk_size[1] = pick_chunk_size();
    r = $urandom_range(9);
    rc_data_size = (r == 0) ? 32'hFFFF_FFFF : (r == 1) ? 32'd0 : $urandom;
    rc_tail      = $urandom_range(4);
    if ($urandom_range(99) >= 55) begin
      case ($urandom_range(1, 12))
        1: rc_riff ^= 32'd1 << $urandom_range(31);
        2: rc_wave ^= 32'd1 << $urandom_range(31);
        3: begin
          rc_junk   = 1'b0;
          rc_fmt_id = $urandom;
        end
        4: begin
          rc_junk   = 1'b1;
          rc_fmt_id = $urandom_range(1) ? TAG_JUNK : $urandom;
        end
        5: rc_fmt_size = $urandom_range(1) ? $urandom_range(40) : $urandom;
        6: rc_audio = $urandom_range(1) ? 16'd0 : 16'($urandom);
        7: rc_chans = $urandom_range(1) ? 16'd0 : 16'($urandom_range(3, 65535));
        8: rc_rate = $urandom_range(1) ? RATE_44K1 + 32'd1 : $urandom;
        9: rc_bits = $urandom_range(1) ? 16'd8 : 16'($urandom);
        10: rc_align = 16'd0;
        11: rc_cut = 1'b1;
        default: rc_flip = 1'b1;
      endcase
    end
  endtask

  task automatic send_random_file();
    int pos;
    random_recipe();
    build_file();
    if (rc_cut)
      cut_file($urandom_range(1, wav_bytes.size() - 1));
    if (rc_flip) begin
      pos = $urandom_range(wav_bytes.size() - 1);
      wav_bytes[pos] = wav_bytes[pos] ^ 8'($urandom_range(1, 255));
    end
    send_file(1'b1, $urandom_range(9) != 0);
  endtask

  // loose bytes with stray start and end marks
  task automatic send_noise(input int count);
    repeat (count) send_item(8'($urandom), $urandom_range(99) < 4, $urandom_range(99) < 6);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // parser must already wait for the riff tag without a first_byte mark
  task automatic test_no_first_after_reset();
    clean_recipe();
    rc_chans     = 16'd1;
    rc_rate      = RATE_32K;
    rc_brate     = 32'd0;
    rc_align     = 16'd2;
    rc_data_size = 32'd0;
    build_file();
    send_file(1'b0, 1'b1);
  endtask

  // good headers at the field extremes, odd and zero size chunks
  task automatic test_valid_extremes();
    clean_recipe();
    rc_fmt_size  = FMT_SIZE_EXT;
    rc_ext       = 16'hFFFF;
    rc_junk      = 1'b1;
    rc_junk_size = 32'd3;
    rc_chunks    = 2;
    rc_chunk_size[0] = 32'd0;
    rc_chunk_size[1] = 32'd5;
    rc_align     = 16'd1;
    rc_brate     = 32'hFFFF_FFFF;
    rc_rate      = RATE_48K;
    rc_data_size = 32'hFFFF_FFFF;
    rc_tail      = 3;
    build_file();
    send_file(1'b1, 1'b1);

    // empty junk chunk, widest block align, file with no end mark
    clean_recipe();
    rc_junk      = 1'b1;
    rc_junk_size = 32'd0;
    rc_align     = 16'hFFFF;
    rc_chans     = 16'd1;
    rc_rate      = RATE_32K;
    rc_data_size = 32'hFFFF_FFFF;
    build_file();
    send_file(1'b1, 1'b0);

    clean_recipe();
    rc_riff_size = 32'hFFFF_FFFF;
    rc_data_size = 32'd0;
    build_file();
    send_file(1'b1, 1'b1);
  endtask

  // one or more files for each error code but truncation
  task automatic test_error_codes();
    for (int k = 0; k < 14; k++) begin
      clean_recipe();
      case (k)
        0: rc_riff = TAG_RIFF ^ 32'h0000_0080;
        1: rc_wave = TAG_WAVE ^ 32'h0100_0000;
        2: rc_fmt_id = TAG_DATA;
        3: begin
          // second fmt tag check after a junk chunk
          rc_junk      = 1'b1;
          rc_junk_size = 32'd2;
          rc_fmt_id    = TAG_JUNK;
        end
        4: rc_fmt_size = 32'd17;
        5: rc_fmt_size = 32'hFFFF_FFFF;
        6: rc_audio = 16'd0;
        7: rc_audio = 16'hFFFF;
        8: rc_chans = 16'd0;
        9: rc_chans = 16'd3;
        10: rc_rate = RATE_44K1 + 32'd1;
        11: rc_bits = 16'd8;
        12: rc_align = 16'd0;
        default: begin
          rc_bits  = 16'hFFFF;
          rc_chans = 16'hFFFF;
        end
      endcase
      build_file();
      send_file(1'b1, 1'b1);
    end
  endtask

  // end marks before the header is complete
  task automatic test_early_end();
    // error and end on the same byte keeps the riff code
    wav_bytes.delete();
    put_le(TAG_RIFF ^ 32'h0100_0000, 4);
    send_file(1'b1, 1'b1);

    // start and end on one single byte
    wav_bytes.delete();
    put_le(TAG_RIFF, 1);
    send_file(1'b1, 1'b1);

    // end inside the junk body
    clean_recipe();
    rc_junk      = 1'b1;
    rc_junk_size = 32'd10;
    build_file();
    cut_file(24);
    send_file(1'b1, 1'b1);

    // end on the third data size byte
    clean_recipe();
    build_file();
    cut_file(wav_bytes.size() - 1);
    send_file(1'b1, 1'b1);
  endtask

  // after a report everything is ignored until the next first_byte
  task automatic test_ignore_after_report();
    clean_recipe();
    rc_tail = 6;
    build_file();
    send_file(1'b1, 1'b1);
    repeat (8) send_item(8'($urandom), 1'b0, 1'b1);
    clean_recipe();
    rc_align = 16'd0;
    build_file();
    send_file(1'b0, 1'b1);
    clean_recipe();
    rc_data_size = 32'd4099;
    build_file();
    send_file(1'b1, 1'b1);
  endtask

  // receiver holds off while short failing files keep coming, so the
  // result register fills and the parser stops taking bytes
  task automatic test_output_backpressure();
    set_idling(0, 0);
    hold_request = 1'b1;
    repeat (40) begin
      wav_bytes.delete();
      put_le($urandom, 4);
      send_file(1'b1, $urandom_range(1));
    end
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  task automatic run_random_phase(input int idle, input int stall);
    int bytes_start;
    int reports_start;
    bytes_start   = bytes_sent;
    reports_start = reports_predicted;
    set_idling(idle, stall);
    while (bytes_sent - bytes_start < 160 || reports_predicted - reports_start < 4) begin
      if ($urandom_range(99) < 8) send_noise($urandom_range(1, 12));
      else send_random_file();
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0);
    run_random_phase(48, 0);
    run_random_phase(0, 48);
    run_random_phase(11, 11);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_no_first_after_reset();
    test_valid_extremes();
    test_error_codes();
    test_early_end();
    test_ignore_after_report();
    test_output_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    // let any stray report show up before judging
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/whp_pkg.sv
rtl/whp_datapath.sv
rtl/whp_ctrl.sv
rtl/wav_header_parser.sv
tb/wav_header_parser_test.sv
